// ===== hdl/pts_pkg.sv =====
// shared types, codes and constants of the task scheduler
`default_nettype none
package pts_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int DELAY_BITS_DEF = 16;
    localparam logic [7:0] IDLE_PRI_RST = 8'd100;
    localparam logic [3:0] DEPTH_MAX = 4'd15;

    localparam logic [2:0] ACT_NEW   = 3'd0;
    localparam logic [2:0] ACT_RUN   = 3'd1;
    localparam logic [2:0] ACT_DELAY = 3'd2;
    localparam logic [2:0] ACT_TICK  = 3'd3;
    localparam logic [2:0] ACT_ISR_IN  = 3'd4;
    localparam logic [2:0] ACT_ISR_OUT = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;
    localparam logic [1:0] ST_UNDER = 2'd3;

    typedef enum logic [1:0] {
        MODE_UNUSED  = 2'd0,
        MODE_READY   = 2'd1,
        MODE_BLOCKED = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SCHED,
        S_TICK,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  priority_req;
        logic [15:0] delay_ticks;
    } t_item;

    typedef struct packed {
        logic [2:0]  running_task;
        logic        running_valid;
        logic        context_switch;
        logic [1:0]  status;
        logic [31:0] tick_total;
        logic [31:0] switch_total;
    } t_result;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan;
        logic sched;
        logic tick;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic want_scan;
        logic want_tick;
        logic scan_last;
        logic tick_last;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/pts_ctrl.sv =====
// sequencing state machine of the task scheduler
`default_nettype none
module pts_ctrl
    import pts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.want_scan) begin
                    n_state = S_SCAN;
                end else if (i_sts.want_tick) begin
                    n_state = S_TICK;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCHED;
                end
            end
            S_SCHED: begin
                o_cmd.sched = 1'b1;
                n_state = S_OUT;
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                if (i_sts.tick_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/pts_dp.sv =====
// task table, counters and slot walks of the task scheduler
`default_nettype none
module pts_dp
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_cmd,
    input  wire t_item   i_item,
    input  wire logic    i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    output t_sts         o_sts,
    output logic         o_strobe,
    output t_result      o_result
);

    localparam int IW = $clog2(TASK_SLOTS);
    localparam int SW = $clog2(TASK_SLOTS + 1);
    localparam int DW = DELAY_BITS;
    localparam logic [31:0] DMAX = 32'((64'd1 << DW) - 64'd1);
    localparam logic [SW-1:0] SLOTS = SW'(TASK_SLOTS);
    localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);

    logic [7:0]    r_pri   [TASK_SLOTS];
    logic [DW-1:0] r_dly   [TASK_SLOTS];
    t_mode         r_mode  [TASK_SLOTS];
    logic [SW-1:0] r_stamp [TASK_SLOTS];

    t_item         r_item;
    logic [SW-1:0] r_used, r_ord, r_blk, r_k, r_tn, r_rel;
    logic [IW-1:0] r_cur, r_idx, r_bi;
    logic          r_started, r_bv, r_sw;
    logic [7:0]    r_bp;
    logic [SW-1:0] r_bs;
    logic [3:0]    r_depth;
    logic [31:0]   r_ticks, r_sws;
    logic [1:0]    r_st;

    logic          cur_ready;
    logic [31:0]   dl32;
    logic [DW-1:0] dl_clamp;
    logic [IW-1:0] new_slot;
    logic          t_hit;
    logic [IW-1:0] t_sel;
    logic          better;

    assign cur_ready = (r_mode[r_cur] == MODE_READY);
    assign dl32      = 32'(r_item.delay_ticks);
    assign dl_clamp  = (dl32 > DMAX) ? DW'(DMAX) : DW'(dl32);
    assign new_slot  = r_used[IW-1:0];

    // blocked slot holding the rank now being walked
    always_comb begin
        t_hit = 1'b0;
        t_sel = '0;
        for (int j = 0; j < TASK_SLOTS; j++) begin
            if (r_mode[j] == MODE_BLOCKED && r_stamp[j] == r_k) begin
                t_hit = 1'b1;
                t_sel = IW'(j);
            end
        end
    end

    assign better = (r_mode[r_idx] == MODE_READY) &&
                    (!r_bv || r_pri[r_idx] < r_bp ||
                     (r_pri[r_idx] == r_bp && r_stamp[r_idx] < r_bs));

    always_comb begin
        o_sts = '0;
        case (r_item.action)
            ACT_NEW:     o_sts.want_scan = (r_used < SLOTS) && r_started;
            ACT_RUN:     o_sts.want_scan = !r_started;
            ACT_DELAY:   o_sts.want_scan = (r_item.delay_ticks != '0) && r_started
                                           && cur_ready;
            ACT_ISR_OUT: o_sts.want_scan = (r_depth == 4'd1) && r_started;
            default:     o_sts.want_scan = 1'b0;
        endcase
        o_sts.want_tick = (r_item.action == ACT_TICK) && (r_blk != '0);
        o_sts.scan_last = (r_idx == LAST);
        o_sts.tick_last = (r_k == r_tn - SW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TASK_SLOTS; j++) begin
                r_pri[j]   <= '0;
                r_dly[j]   <= '0;
                r_mode[j]  <= MODE_UNUSED;
                r_stamp[j] <= '0;
            end
            r_pri[0]  <= IDLE_PRI_RST;
            r_mode[0] <= MODE_READY;
            r_used    <= SW'(1);
            r_ord     <= SW'(1);
            r_blk     <= '0;
            r_cur     <= '0;
            r_started <= 1'b0;
            r_depth   <= '0;
            r_ticks   <= '0;
            r_sws     <= '0;
            r_k       <= '0;
            r_tn      <= '0;
            r_rel     <= '0;
            r_idx     <= '0;
            r_bv      <= 1'b0;
            r_sw      <= 1'b0;
            r_st      <= ST_OK;
            o_strobe  <= 1'b0;
        end else begin
            o_strobe <= i_cmd.emit;
            if (i_cfg_we) begin
                r_pri[0] <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_item <= i_item;
                r_sw   <= 1'b0;
                r_st   <= ST_OK;
            end
            if (i_cmd.exec) begin
                r_idx <= '0;
                r_bv  <= 1'b0;
                r_k   <= '0;
                r_rel <= '0;
                r_tn  <= r_blk;
                case (r_item.action)
                    ACT_NEW: begin
                        if (r_used >= SLOTS) begin
                            r_st <= ST_FULL;
                        end else begin
                            r_pri[new_slot]   <= r_item.priority_req;
                            r_dly[new_slot]   <= '0;
                            r_mode[new_slot]  <= MODE_READY;
                            r_stamp[new_slot] <= r_ord;
                            r_ord  <= r_ord + SW'(1);
                            r_used <= r_used + SW'(1);
                        end
                    end
                    ACT_DELAY: begin
                        if (r_item.delay_ticks != '0) begin
                            if (!r_started || !cur_ready) begin
                                r_st <= ST_NONE;
                            end else begin
                                // ready ranks above the leaving task close up
                                for (int j = 0; j < TASK_SLOTS; j++) begin
                                    if (r_mode[j] == MODE_READY &&
                                        r_stamp[j] > r_stamp[r_cur]) begin
                                        r_stamp[j] <= r_stamp[j] - SW'(1);
                                    end
                                end
                                r_dly[r_cur]   <= dl_clamp;
                                r_mode[r_cur]  <= MODE_BLOCKED;
                                r_stamp[r_cur] <= r_blk;
                                r_ord <= r_ord - SW'(1);
                                r_blk <= r_blk + SW'(1);
                            end
                        end
                    end
                    ACT_TICK: begin
                        r_ticks <= r_ticks + 32'd1;
                    end
                    ACT_ISR_IN: begin
                        if (r_depth < DEPTH_MAX) begin
                            r_depth <= r_depth + 4'd1;
                        end
                    end
                    ACT_ISR_OUT: begin
                        if (r_depth == '0) begin
                            r_st <= ST_UNDER;
                        end else begin
                            r_depth <= r_depth - 4'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.scan) begin
                if (better) begin
                    r_bv <= 1'b1;
                    r_bi <= r_idx;
                    r_bp <= r_pri[r_idx];
                    r_bs <= r_stamp[r_idx];
                end
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.sched) begin
                if (!r_bv) begin
                    r_st <= ST_NONE;
                end else if (r_item.action == ACT_RUN || r_bi != r_cur) begin
                    r_started <= 1'b1;
                    r_cur     <= r_bi;
                    r_sws     <= r_sws + 32'd1;
                    r_sw      <= 1'b1;
                end
            end
            if (i_cmd.tick) begin
                r_k <= r_k + SW'(1);
                if (t_hit) begin
                    if (r_dly[t_sel] <= DW'(1)) begin
                        r_dly[t_sel]   <= '0;
                        r_mode[t_sel]  <= MODE_READY;
                        r_stamp[t_sel] <= r_ord;
                        r_ord <= r_ord + SW'(1);
                        r_blk <= r_blk - SW'(1);
                        r_rel <= r_rel + SW'(1);
                    end else begin
                        r_dly[t_sel]   <= r_dly[t_sel] - DW'(1);
                        r_stamp[t_sel] <= r_k - r_rel;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_result.running_task   <= 3'(r_cur);
            o_result.running_valid  <= r_started && cur_ready;
            o_result.context_switch <= r_sw;
            o_result.status         <= r_st;
            o_result.tick_total     <= r_ticks;
            o_result.switch_total   <= r_sws;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/priority_task_scheduler_with_delays_unit.sv =====
// top level of the priority task scheduler with tick delays
`default_nettype none
// One action is taken when start is high and busy is low, and exactly one
// result beat follows on o_result with o_strobe high for a single cycle;
// the receiver cannot stall it. o_strobe rises after the execute and output
// states when no scheduling pass is needed; when the action selects a task
// (run before start, new task with a free slot once started, nonzero delay
// of a ready running task, final isr exit), a walk over every task slot, one
// per cycle, and a schedule state come in between, and for a tick a walk over
// the blocked tasks, one per cycle in the order they were blocked. busy stays
// high from the accepting edge until the result beat is issued; the next
// action may be taken at the edge that ends the strobe cycle.
// The idle priority may be written at any time the block is idle and also
// lands in slot zero at once.
module priority_task_scheduler_with_delays_unit
    import pts_pkg::*;
#(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int DELAY_BITS = DELAY_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire t_item      i_item,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_data,
    output logic            o_strobe,
    output t_result         o_result
);

    // command and status between sequencer and task table
    t_cmd cmd;
    t_sts sts;

    pts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    pts_dp #(
        .TASK_SLOTS (TASK_SLOTS),
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_sts      (sts),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

`ifndef SYNTHESIS
    // the block goes busy right after taking an action
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("action taken but not busy");

    // leaving busy always issues the result beat
    a_done_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe) else $error("busy dropped with no result");

    // one beat per action, never two in a row
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("result beat repeated");
`endif

endmodule
`default_nettype wire
